[src/rpr_pkg.sv]
// Shared types, widths and arithmetic helpers for the reprojection residual block.
`timescale 1ns / 1ps
package rpr_pkg;

    // Datapath widths.
    localparam int C_W  = 41;   // camera-frame coordinate, signed Q25.16
    localparam int M_W  = 66;   // numerator magnitude of the projection
    localparam int D_W  = 40;   // positive depth used as divisor
    localparam int Q_W  = 34;   // quotient bits kept before saturation
    localparam int CP_W = 25;   // center minus observed pixel

    // Pipeline latencies of the parts.
    localparam int XF_LAT  = 5;
    localparam int PJ_LAT  = 3;
    localparam int DIV_LAT = Q_W + 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
    localparam logic [1:0] CFG_CENTER_X = 2'd1;
    localparam logic [1:0] CFG_FOCAL_Y  = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y = 2'd3;

    localparam logic [23:0] RST_FOCAL_X  = 24'd256000;
    localparam logic [23:0] RST_CENTER_X = 24'd163840;
    localparam logic [23:0] RST_FOCAL_Y  = 24'd256000;
    localparam logic [23:0] RST_CENTER_Y = 24'd122880;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        pixel_u;
        logic [23:0]        pixel_v;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] residual_u;
        logic signed [31:0] residual_v;
        logic               depth_invalid;
    } t_out_beat;

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] center_x;
        logic [23:0] focal_y;
        logic [23:0] center_y;
    } t_cam_cfg;

    // One axis worth of work handed to a divider.
    typedef struct packed {
        logic [M_W-1:0]         num;
        logic [D_W-1:0]         den;
        logic                   neg;
        logic                   zero;
        logic signed [CP_W-1:0] cp;
    } t_div_req;

    // Round a rotation entry from scale 2^28 to 2^24, ties away from zero.
    function automatic logic signed [30:0] rnd_rot(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = v + (v[34] ? 35'sd7 : 35'sd8);
        return t[34:4];
    endfunction

    // Round an accumulator from scale 2^40 to 2^16, ties away from zero.
    function automatic logic signed [C_W-1:0] rnd_acc(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v + (v[64] ? 65'sd8388607 : 65'sd8388608);
        return t[64:24];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -37'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[src/rpr_in_if.sv]
// Input channel carrying one point beat.
`timescale 1ns / 1ps
interface rpr_in_if;
    import rpr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/rpr_out_if.sv]
// Output channel carrying one residual beat.
`timescale 1ns / 1ps
interface rpr_out_if;
    import rpr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/rpr_xform.sv]
// Quaternion to rotation and rigid transform into the camera frame, five stages.
`timescale 1ns / 1ps
module rpr_xform (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  rpr_pkg::t_in_beat            i_beat,
    output logic signed [rpr_pkg::C_W-1:0] o_cam [0:2],
    output logic [23:0]                  o_pix_u,
    output logic [23:0]                  o_pix_v
);
    import rpr_pkg::*;

    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

    // Stage A: quaternion products and operand capture.
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;
    logic signed [31:0] r_p_a [0:2];
    logic signed [31:0] r_t_a [0:2];
    logic [23:0]        r_pu_a, r_pv_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= i_beat.quat_x * i_beat.quat_x;
            r_yy <= i_beat.quat_y * i_beat.quat_y;
            r_zz <= i_beat.quat_z * i_beat.quat_z;
            r_xy <= i_beat.quat_x * i_beat.quat_y;
            r_xz <= i_beat.quat_x * i_beat.quat_z;
            r_yz <= i_beat.quat_y * i_beat.quat_z;
            r_xw <= i_beat.quat_x * i_beat.quat_w;
            r_yw <= i_beat.quat_y * i_beat.quat_w;
            r_zw <= i_beat.quat_z * i_beat.quat_w;
            r_p_a[0] <= i_beat.point_x;
            r_p_a[1] <= i_beat.point_y;
            r_p_a[2] <= i_beat.point_z;
            r_t_a[0] <= i_beat.shift_x;
            r_t_a[1] <= i_beat.shift_y;
            r_t_a[2] <= i_beat.shift_z;
            r_pu_a   <= i_beat.pixel_u;
            r_pv_a   <= i_beat.pixel_v;
        end
    end

    // Stage B: rotation matrix entries, rounded to scale 2^24.
    logic signed [30:0] r_rot [0:8];
    logic signed [31:0] r_p_b [0:2];
    logic signed [31:0] r_t_b [0:2];
    logic [23:0]        r_pu_b, r_pv_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot[0] <= rnd_rot(ONE_Q28 - ((35'(r_yy) + 35'(r_zz)) <<< 1));
            r_rot[1] <= rnd_rot((35'(r_xy) - 35'(r_zw)) <<< 1);
            r_rot[2] <= rnd_rot((35'(r_xz) + 35'(r_yw)) <<< 1);
            r_rot[3] <= rnd_rot((35'(r_xy) + 35'(r_zw)) <<< 1);
            r_rot[4] <= rnd_rot(ONE_Q28 - ((35'(r_xx) + 35'(r_zz)) <<< 1));
            r_rot[5] <= rnd_rot((35'(r_yz) - 35'(r_xw)) <<< 1);
            r_rot[6] <= rnd_rot((35'(r_xz) - 35'(r_yw)) <<< 1);
            r_rot[7] <= rnd_rot((35'(r_yz) + 35'(r_xw)) <<< 1);
            r_rot[8] <= rnd_rot(ONE_Q28 - ((35'(r_xx) + 35'(r_yy)) <<< 1));
            r_p_b  <= r_p_a;
            r_t_b  <= r_t_a;
            r_pu_b <= r_pu_a;
            r_pv_b <= r_pv_a;
        end
    end

    // Stage C: the nine rotation products.
    logic signed [62:0] r_prod [0:8];
    logic signed [31:0] r_t_c [0:2];
    logic [23:0]        r_pu_c, r_pv_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= r_rot[k] * r_p_b[k % 3];
            end
            r_t_c  <= r_t_b;
            r_pu_c <= r_pu_b;
            r_pv_c <= r_pv_b;
        end
    end

    // Stage D: row sums with the translation at scale 2^40.
    logic signed [64:0] r_acc [0:2];
    logic [23:0]        r_pu_d, r_pv_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= (65'(r_t_c[i]) <<< 24) + 65'(r_prod[3*i]) +
                            65'(r_prod[3*i+1]) + 65'(r_prod[3*i+2]);
            end
            r_pu_d <= r_pu_c;
            r_pv_d <= r_pv_c;
        end
    end

    // Stage E: round back to scale 2^16 (Q25.16).
    logic signed [C_W-1:0] r_cam [0:2];
    logic [23:0]           r_pu_e, r_pv_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_cam[i] <= rnd_acc(r_acc[i]);
            end
            r_pu_e <= r_pu_d;
            r_pv_e <= r_pv_d;
        end
    end

    assign o_cam   = r_cam;
    assign o_pix_u = r_pu_e;
    assign o_pix_v = r_pv_e;

endmodule

[src/rpr_proj.sv]
// Pinhole projection numerators and divider requests, three stages.
`timescale 1ns / 1ps
module rpr_proj (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  rpr_pkg::t_cam_cfg              i_cfg,
    input  logic signed [rpr_pkg::C_W-1:0] i_cam [0:2],
    input  logic [23:0]                    i_pix_u,
    input  logic [23:0]                    i_pix_v,
    output rpr_pkg::t_div_req              o_req_u,
    output rpr_pkg::t_div_req              o_req_v
);
    import rpr_pkg::*;

    localparam int LO_W = 20;
    localparam int HI_W = C_W - LO_W;

    // Stage F: focal length times coordinate, split in two partial products.
    logic [23+LO_W:0]          r_lo_u, r_lo_v;
    logic signed [24+HI_W:0]   r_hi_u, r_hi_v;
    logic signed [CP_W-1:0]    r_cp_u_f, r_cp_v_f;
    logic [D_W-1:0]            r_den_f;
    logic                      r_zero_f;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_u   <= i_cfg.focal_x * i_cam[0][LO_W-1:0];
            r_lo_v   <= i_cfg.focal_y * i_cam[1][LO_W-1:0];
            r_hi_u   <= $signed({1'b0, i_cfg.focal_x}) * $signed(i_cam[0][C_W-1:LO_W]);
            r_hi_v   <= $signed({1'b0, i_cfg.focal_y}) * $signed(i_cam[1][C_W-1:LO_W]);
            r_cp_u_f <= $signed({1'b0, i_cfg.center_x}) - $signed({1'b0, i_pix_u});
            r_cp_v_f <= $signed({1'b0, i_cfg.center_y}) - $signed({1'b0, i_pix_v});
            r_den_f  <= i_cam[2][D_W-1:0];
            r_zero_f <= (i_cam[2] <= 0);
        end
    end

    // Stage G: combine the partial products.
    logic signed [M_W-1:0]  r_n_u, r_n_v;
    logic signed [CP_W-1:0] r_cp_u_g, r_cp_v_g;
    logic [D_W-1:0]         r_den_g;
    logic                   r_zero_g;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_u    <= (M_W'(r_hi_u) <<< LO_W) + M_W'(r_lo_u);
            r_n_v    <= (M_W'(r_hi_v) <<< LO_W) + M_W'(r_lo_v);
            r_cp_u_g <= r_cp_u_f;
            r_cp_v_g <= r_cp_v_f;
            r_den_g  <= r_den_f;
            r_zero_g <= r_zero_f;
        end
    end

    // Stage H: magnitude plus half the divisor for rounded division.
    t_div_req r_req_u, r_req_v;
    logic [M_W-1:0] w_mag_u, w_mag_v, w_half;

    always_comb begin
        w_mag_u = r_n_u[M_W-1] ? M_W'(-r_n_u) : M_W'(r_n_u);
        w_mag_v = r_n_v[M_W-1] ? M_W'(-r_n_v) : M_W'(r_n_v);
        w_half  = M_W'(r_den_g >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req_u.num  <= w_mag_u + w_half;
            r_req_u.den  <= r_den_g;
            r_req_u.neg  <= r_n_u[M_W-1];
            r_req_u.zero <= r_zero_g;
            r_req_u.cp   <= r_cp_u_g;
            r_req_v.num  <= w_mag_v + w_half;
            r_req_v.den  <= r_den_g;
            r_req_v.neg  <= r_n_v[M_W-1];
            r_req_v.zero <= r_zero_g;
            r_req_v.cp   <= r_cp_v_g;
        end
    end

    assign o_req_u = r_req_u;
    assign o_req_v = r_req_v;

endmodule

[src/rpr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with offset and saturation.
`timescale 1ns / 1ps
module rpr_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  rpr_pkg::t_div_req    i_req,
    output logic signed [31:0]   o_res,
    output logic                 o_zero
);
    import rpr_pkg::*;

    typedef struct packed {
        logic [D_W-1:0]         rem;
        logic [Q_W-1:0]         low;
        logic [Q_W-1:0]         quo;
        logic [D_W-1:0]         den;
        logic                   ovf;
        logic                   neg;
        logic                   zero;
        logic signed [CP_W-1:0] cp;
    } t_div_st;

    t_div_st r_st [0:Q_W];

    // Entry stage: upper numerator bits start the remainder; a quotient
    // too large for the kept bits is flagged and saturates later.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= D_W'(i_req.num[M_W-1:Q_W]);
            r_st[0].low  <= i_req.num[Q_W-1:0];
            r_st[0].quo  <= '0;
            r_st[0].den  <= i_req.den;
            r_st[0].ovf  <= D_W'(i_req.num[M_W-1:Q_W]) >= i_req.den;
            r_st[0].neg  <= i_req.neg;
            r_st[0].zero <= i_req.zero;
            r_st[0].cp   <= i_req.cp;
        end
    end

    // One compare and subtract per stage.
    for (genvar g = 0; g < Q_W; g++) begin : g_step
        logic [D_W:0] w_trial;
        logic         w_ge;
        t_div_st      w_nxt;

        always_comb begin
            w_trial = {r_st[g].rem, r_st[g].low[Q_W-1-g]};
            w_ge    = w_trial >= {1'b0, r_st[g].den};
            w_nxt   = r_st[g];
            w_nxt.rem = w_ge ? D_W'(w_trial - {1'b0, r_st[g].den}) : w_trial[D_W-1:0];
            w_nxt.quo[Q_W-1-g] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g+1] <= w_nxt;
            end
        end
    end

    // Final stage: sign, pixel offset, saturation and the invalid-depth override.
    logic [Q_W-1:0]        w_qmag;
    logic signed [Q_W+1:0] w_qs;
    logic signed [36:0]    w_sum;
    logic signed [31:0]    r_res;
    logic                  r_zero;

    always_comb begin
        w_qmag = r_st[Q_W].ovf ? '1 : r_st[Q_W].quo;
        w_qs   = $signed({2'b00, w_qmag});
        if (r_st[Q_W].neg) begin
            w_qs = -w_qs;
        end
        w_sum  = 37'(w_qs) + 37'(r_st[Q_W].cp);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= r_st[Q_W].zero ? 32'sd0 : sat32(w_sum);
            r_zero <= r_st[Q_W].zero;
        end
    end

    assign o_res  = r_res;
    assign o_zero = r_zero;

endmodule

[src/pinhole_reprojection_residual.sv]
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// The depth divide is a restoring divider with 34 compare stages, one quotient bit per stage.
// Reset clears every stage valid bit and loads the default camera intrinsics.
// Payload registers are not reset.
`timescale 1ns / 1ps
module pinhole_reprojection_residual (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpr_in_if.sink        i_in,
    rpr_out_if.source     o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);
    import rpr_pkg::*;

    localparam int LAT = XF_LAT + PJ_LAT + DIV_LAT;

    // Intrinsics registers.
    t_cam_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= RST_FOCAL_X;
            r_cfg.center_x <= RST_CENTER_X;
            r_cfg.focal_y  <= RST_FOCAL_Y;
            r_cfg.center_y <= RST_CENTER_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCAL_X:  r_cfg.focal_x  <= i_cfg_data;
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                CFG_FOCAL_Y:  r_cfg.focal_y  <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline advance: move whenever the output beat is absent or taken.
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // Datapath.
    logic signed [C_W-1:0] w_cam [0:2];
    logic [23:0]           w_pix_u, w_pix_v;
    t_div_req              w_req_u, w_req_v;
    logic signed [31:0]    w_res_u, w_res_v;
    logic                  w_zero_u, w_zero_v;

    rpr_xform u_xform (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_beat  (i_in.data),
        .o_cam   (w_cam),
        .o_pix_u (w_pix_u),
        .o_pix_v (w_pix_v)
    );

    rpr_proj u_proj (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_cam   (w_cam),
        .i_pix_u (w_pix_u),
        .i_pix_v (w_pix_v),
        .o_req_u (w_req_u),
        .o_req_v (w_req_v)
    );

    rpr_div u_div_u (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_req  (w_req_u),
        .o_res  (w_res_u),
        .o_zero (w_zero_u)
    );

    rpr_div u_div_v (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_req  (w_req_v),
        .o_res  (w_res_v),
        .o_zero (w_zero_v)
    );

    assign o_out.data.residual_u    = w_res_u;
    assign o_out.data.residual_v    = w_res_v;
    assign o_out.data.depth_invalid = w_zero_u;

    // The valid line holds its contents across a stall.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_en)) |-> (r_vld == $past(r_vld)))
        else $error("valid line moved during a stall");

    // Leaving reset, no beat is in flight.
    a_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // A bad depth gives zero residuals.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.depth_invalid) |->
        (w_res_u == 32'sd0 && w_res_v == 32'sd0 && w_zero_v))
        else $error("invalid depth with nonzero residual");

endmodule
